/* rtl/core/spq_pkg.sv */
// Shared types and sizes for the sorted priority queue core.
// No dependencies; imported by spq_cell and sorted_priority_queue_core.
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int PRIO_WIDTH  = 8;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // One stored entry
  typedef struct packed {
    logic                  valid;
    logic [PRIO_WIDTH-1:0] prio;
    logic [DATA_WIDTH-1:0] data;
  } slot_t;

  // What a cell hands to its right neighbor
  typedef struct packed {
    slot_t slot;
    logic  keep;  // this cell holds its entry through an insert
  } link_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic                  en;
    logic                  remove;
    logic [PRIO_WIDTH-1:0] prio;
    logic [DATA_WIDTH-1:0] data;
  } cmd_t;

endpackage

/* rtl/core/sorted_priority_queue_core.sv */
// Top level of the sorted priority queue: chain of spq_cell slots plus count and result regs.
// Depends on spq_pkg and spq_cell.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  request   | start_i / busy_o     | req_type_i, entry_prio_i, entry_data_i
//  result    | done_o (one cycle)   | accepted_o, head_valid_o, head_prio_o,
//            |                      | head_data_o, entry_count_o
//
// Every cell compares against the new priority and shifts in the same cycle, so a
// request is taken each cycle and its result shows with done_o on the next cycle.
// busy_o stays low; the result cannot be stalled and lasts one cycle.
// Reset clears the slot valid bits, the count and the result strobe; no clearing pass.
module sorted_priority_queue_core import spq_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         req_type_i,
  input  logic signed [PRIO_WIDTH-1:0] entry_prio_i,
  input  logic        [DATA_WIDTH-1:0] entry_data_i,
  output logic                         done_o,
  output logic                         accepted_o,
  output logic                         head_valid_o,
  output logic signed [PRIO_WIDTH-1:0] head_prio_o,
  output logic        [DATA_WIDTH-1:0] head_data_o,
  output logic        [CNT_W-1:0]      entry_count_o
);

  logic             take;
  logic             full;
  logic             accept;
  cmd_t             cmd;
  link_t            link [QUEUE_DEPTH];
  logic [CNT_W-1:0] count_q, count_d;
  logic             done_q, accepted_q;

  assign busy_o = 1'b0;
  assign take   = start_i && !busy_o;
  assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
  assign accept = !(req_type_i == REQ_INSERT && full);

  // Broadcast command, dropped inserts do not reach the cells
  assign cmd.en     = take && accept;
  assign cmd.remove = (req_type_i == REQ_REMOVE);
  assign cmd.prio   = entry_prio_i;
  assign cmd.data   = entry_data_i;

  // Cell chain, head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    link_t left;
    slot_t right;
    if (i == 0) begin : g_first
      assign left.slot = '0;
      assign left.keep = 1'b1;
    end else begin : g_mid
      assign left = link[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = link[i+1].slot;
    end
    spq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .left_i (left),
      .right_i(right),
      .link_o (link[i])
    );
  end

  // Entry count
  always_comb begin
    count_d = count_q;
    if (cmd.en) begin
      if (!cmd.remove) begin
        count_d = count_q + CNT_W'(1);
      end else if (count_q != '0) begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      done_q     <= 1'b0;
      accepted_q <= 1'b0;
    end else begin
      count_q    <= count_d;
      done_q     <= take;
      if (take) begin
        accepted_q <= accept;
      end
    end
  end

  // Result: head comes straight from the first cell
  assign done_o        = done_q;
  assign accepted_o    = accepted_q;
  assign head_valid_o  = link[0].slot.valid;
  assign head_prio_o   = link[0].slot.valid ? link[0].slot.prio : '0;
  assign head_data_o   = link[0].slot.valid ? link[0].slot.data : '0;
  assign entry_count_o = count_q;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count beyond depth");

  a_head_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_o == (count_q != '0))
    else $error("head valid disagrees with count");

  a_tail_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link[QUEUE_DEPTH-1].slot.valid == full)
    else $error("last slot valid disagrees with full count");

  a_reject_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !accept |=> done_o && !accepted_o && $stable(count_q))
    else $error("rejected insert changed state");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> done_o)
    else $error("missing result strobe");

endmodule

/* rtl/core/spq_cell.sv */
// One slot of the sorted chain: holds an entry, shifts right on insert, left on remove.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  input  link_t left_i,
  input  slot_t right_i,
  output link_t link_o
);

  logic                  valid_q, valid_d;
  logic [PRIO_WIDTH-1:0] prio_q, prio_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  keep;

  // Entry stays put when it is at least as urgent as the new one
  assign keep = valid_q && ($signed(prio_q) >= $signed(cmd_i.prio));

  // Next slot content
  always_comb begin
    valid_d = valid_q;
    prio_d  = prio_q;
    data_d  = data_q;
    if (cmd_i.en) begin
      if (cmd_i.remove) begin
        valid_d = right_i.valid;
        prio_d  = right_i.prio;
        data_d  = right_i.data;
      end else if (!keep) begin
        if (left_i.keep) begin
          // insertion point
          valid_d = 1'b1;
          prio_d  = cmd_i.prio;
          data_d  = cmd_i.data;
        end else begin
          valid_d = left_i.slot.valid;
          prio_d  = left_i.slot.prio;
          data_d  = left_i.slot.data;
        end
      end
    end
  end

  // Valid bit is control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    data_q <= data_d;
  end

  assign link_o.slot.valid = valid_q;
  assign link_o.slot.prio  = prio_q;
  assign link_o.slot.data  = data_q;
  assign link_o.keep       = keep;

endmodule
